// ===== design/msqh_pkg.sv =====
// Shared types, constants and helpers of the magnetometer sample qualifier.
package msqh_pkg;

  localparam int unsigned MaxCheckedRegs = 4;
  localparam int unsigned IdxW = $clog2(MaxCheckedRegs);

  localparam logic signed [15:0] SampleMin = 16'sh8000;
  localparam logic signed [15:0] SampleMax = 16'sh7fff;

  // configuration register indexes
  localparam logic [2:0] RegReadyMask     = 3'd0;
  localparam logic [2:0] RegOverflowMask  = 3'd1;
  localparam logic [2:0] RegFailureLimit  = 3'd2;
  localparam logic [2:0] RegCheckInterval = 3'd3;
  localparam logic [2:0] RegCheckedCount  = 3'd4;
  localparam logic [2:0] RegSetMasks      = 3'd5;
  localparam logic [2:0] RegClearMasks    = 3'd6;

  localparam logic [7:0]  ReadyMaskRst     = 8'd1;
  localparam logic [7:0]  OverflowMaskRst  = 8'd2;
  localparam logic [7:0]  FailureLimitRst  = 8'd10;
  localparam logic [31:0] CheckIntervalRst = 32'd100000;
  localparam logic [2:0]  CheckedCountRst  = 3'd3;

  localparam logic [7:0] CounterTop = 8'hff;

  typedef struct packed {
    logic [7:0]  ready_mask;
    logic [7:0]  overflow_mask;
    logic [7:0]  failure_limit;
    logic [31:0] check_interval_us;
    logic [2:0]  checked_count;
    logic [31:0] set_masks;
    logic [31:0] clear_masks;
  } cfg_t;

  typedef struct packed {
    logic            check_done;
    logic            bad_register;
    logic            reset_request;
    logic [IdxW-1:0] next_check_index;
  } health_t;

  // result item, first field highest
  typedef struct packed {
    logic [IdxW-1:0]    next_check_index;
    logic               reset_request;
    logic               bad_register;
    logic               check_done;
    logic               bad_transfer;
    logic               overflow_seen;
    logic signed [15:0] mag_z;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_x;
    logic               publish_valid;
  } result_t;

  // clamp the programmed count into 1..MaxCheckedRegs
  function automatic logic [2:0] eff_count(input logic [2:0] cnt);
    logic [2:0] c;
    c = cnt;
    if (c == 3'd0) c = 3'd1;
    if (c > 3'(MaxCheckedRegs)) c = 3'(MaxCheckedRegs);
    return c;
  endfunction

  // (idx + 1) mod cnt, for idx 0..3 and cnt 1..4
  function automatic logic [IdxW-1:0] next_index(input logic [IdxW-1:0] idx,
                                                 input logic [2:0] cnt);
    logic [2:0] n;
    logic [2:0] r;
    n = 3'(idx) + 3'd1;
    r = n;
    case (cnt)
      3'd1: r = 3'd0;
      3'd2: r = {2'b00, n[0]};
      3'd3: r = (n == 3'd3) ? 3'd0 : ((n == 3'd4) ? 3'd1 : n);
      3'd4: r = (n == 3'd4) ? 3'd0 : n;
      default: r = 3'd0;
    endcase
    return r[IdxW-1:0];
  endfunction

endpackage

// ===== design/msqh_axis_lane.sv =====
// One axis lane: holds the previous sample, flags a change and orients the value.
module msqh_axis_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               negate,
  input  logic signed [15:0] sample,
  output logic               changed,
  output logic signed [15:0] oriented
);

  logic signed [15:0] prev_r;
  logic signed [15:0] prev_nxt;

  assign changed  = (sample != prev_r);
  assign prev_nxt = load ? sample : prev_r;

  always_comb begin
    if (!negate) begin
      oriented = sample;
    end else if (sample == msqh_pkg::SampleMin) begin
      oriented = msqh_pkg::SampleMax;
    end else begin
      oriented = -sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

// ===== design/msqh_health.sv =====
// Failure counter and round-robin register check.
module msqh_health (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        publish,
  input  logic [7:0]                  readback,
  input  logic [31:0]                 now_us,
  input  msqh_pkg::cfg_t              cfg,
  output msqh_pkg::health_t           health
);

  logic [7:0]                  fail_cnt_r, fail_cnt_nxt;
  logic [msqh_pkg::IdxW-1:0]   check_idx_r, check_idx_nxt;
  logic [31:0]                 last_check_r, last_check_nxt;

  logic [7:0]  cnt_step;
  logic        over_limit;
  logic        elapsed;
  logic        run_check;
  logic [7:0]  set_m;
  logic [7:0]  clr_m;
  logic        pass;

  always_comb begin
    case (check_idx_r)
      2'd0: begin set_m = cfg.set_masks[7:0];   clr_m = cfg.clear_masks[7:0];   end
      2'd1: begin set_m = cfg.set_masks[15:8];  clr_m = cfg.clear_masks[15:8];  end
      2'd2: begin set_m = cfg.set_masks[23:16]; clr_m = cfg.clear_masks[23:16]; end
      default: begin set_m = cfg.set_masks[31:24]; clr_m = cfg.clear_masks[31:24]; end
    endcase
  end

  // zero masks can never fail
  assign pass = ((readback & set_m) == set_m) && ((readback & clr_m) == 8'd0);

  assign elapsed = (now_us - last_check_r) > cfg.check_interval_us;

  always_comb begin
    if (publish) begin
      cnt_step = (fail_cnt_r != 8'd0) ? fail_cnt_r - 8'd1 : fail_cnt_r;
    end else begin
      cnt_step = (fail_cnt_r != msqh_pkg::CounterTop) ? fail_cnt_r + 8'd1 : fail_cnt_r;
    end
  end

  assign over_limit = !publish && (cnt_step > cfg.failure_limit);
  assign run_check  = !over_limit && (!publish || elapsed);

  always_comb begin
    fail_cnt_nxt   = cnt_step;
    check_idx_nxt  = check_idx_r;
    last_check_nxt = last_check_r;
    if (over_limit) begin
      fail_cnt_nxt = 8'd0;
    end else if (run_check) begin
      if (pass) begin
        last_check_nxt = now_us;
        check_idx_nxt  = msqh_pkg::next_index(check_idx_r,
                                              msqh_pkg::eff_count(cfg.checked_count));
      end else begin
        fail_cnt_nxt = 8'd0;
      end
    end
  end

  assign health.check_done       = run_check;
  assign health.bad_register     = run_check && !pass;
  assign health.reset_request    = over_limit || (run_check && !pass);
  assign health.next_check_index = check_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_cnt_r   <= '0;
      check_idx_r  <= '0;
      last_check_r <= '0;
    end else if (accept) begin
      fail_cnt_r   <= fail_cnt_nxt;
      check_idx_r  <= check_idx_nxt;
      last_check_r <= last_check_nxt;
    end
  end

endmodule

// ===== design/mag_sample_qualifier_health_core.sv =====
// Top level of the magnetometer sample qualifier and health monitor.
//
// One poll result enters per item and yields exactly one result item. The
// block takes an item every clock cycle unless the output stalls: three axis
// lanes compare the new triple with the previous good one and orient it (X
// kept, Y and Z negated with saturation) side by side, a merge step forms the
// publish decision, and the health unit updates the failure counter and runs
// the round-robin set/clear mask check in the same cycle. The result is held
// in a single output register, and a new item is taken whenever that register
// is empty or being drained. Configuration registers are written through the
// cfg port, which is always ready; writes to an index beyond the list are
// dropped. Reset is synchronous and active low, and no clearing pass is
// needed after it.
module mag_sample_qualifier_health_core (
  input  logic         clk,
  input  logic         rst_n,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // poll items
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] transfer_ok, [16:1] x_raw, [32:17] y_raw, [48:33] z_raw,
  // [56:49] status_byte, [64:57] check_readback, [96:65] now_us, [103:97] zero
  input  logic [103:0] in_tdata,
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] publish_valid, [16:1] mag_x, [32:17] mag_y, [48:33] mag_z,
  // [49] overflow_seen, [50] bad_transfer, [51] check_done, [52] bad_register,
  // [53] reset_request, [55:54] next_check_index
  output logic [55:0]  out_tdata
);

  // ---- configuration registers
  msqh_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_mask        <= msqh_pkg::ReadyMaskRst;
      cfg_r.overflow_mask     <= msqh_pkg::OverflowMaskRst;
      cfg_r.failure_limit     <= msqh_pkg::FailureLimitRst;
      cfg_r.check_interval_us <= msqh_pkg::CheckIntervalRst;
      cfg_r.checked_count     <= msqh_pkg::CheckedCountRst;
      cfg_r.set_masks         <= '0;
      cfg_r.clear_masks       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msqh_pkg::RegReadyMask:     cfg_r.ready_mask        <= cfg_data[7:0];
        msqh_pkg::RegOverflowMask:  cfg_r.overflow_mask     <= cfg_data[7:0];
        msqh_pkg::RegFailureLimit:  cfg_r.failure_limit     <= cfg_data[7:0];
        msqh_pkg::RegCheckInterval: cfg_r.check_interval_us <= cfg_data;
        msqh_pkg::RegCheckedCount:  cfg_r.checked_count     <= cfg_data[2:0];
        msqh_pkg::RegSetMasks:      cfg_r.set_masks         <= cfg_data;
        msqh_pkg::RegClearMasks:    cfg_r.clear_masks       <= cfg_data;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // ---- input unpack
  logic               transfer_ok;
  logic signed [15:0] x_raw, y_raw, z_raw;
  logic [7:0]         status_byte;
  logic [7:0]         check_readback;
  logic [31:0]        now_us;

  assign transfer_ok    = in_tdata[0];
  assign x_raw          = in_tdata[16:1];
  assign y_raw          = in_tdata[32:17];
  assign z_raw          = in_tdata[48:33];
  assign status_byte    = in_tdata[56:49];
  assign check_readback = in_tdata[64:57];
  assign now_us         = in_tdata[96:65];

  // ---- handshake: one output register, refilled whenever it is empty or being drained
  logic            out_valid_r, out_valid_nxt;
  msqh_pkg::result_t out_data_r;
  msqh_pkg::result_t res;
  logic            accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // ---- axis lanes
  logic               chg_x, chg_y, chg_z;
  logic signed [15:0] or_x, or_y, or_z;
  logic               lane_load;

  assign lane_load = accept && transfer_ok;  // failed transfers keep history

  msqh_axis_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .load(lane_load), .negate(1'b0),
    .sample(x_raw), .changed(chg_x), .oriented(or_x)
  );
  msqh_axis_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .load(lane_load), .negate(1'b1),
    .sample(y_raw), .changed(chg_y), .oriented(or_y)
  );
  msqh_axis_lane u_lane_z (
    .clk(clk), .rst_n(rst_n), .load(lane_load), .negate(1'b1),
    .sample(z_raw), .changed(chg_z), .oriented(or_z)
  );

  // ---- merge: publish decision
  logic status_ready, ovf, publish;

  assign status_ready = (status_byte & cfg_r.ready_mask) != 8'd0;
  assign ovf          = (status_byte & cfg_r.overflow_mask) != 8'd0;
  assign publish      = transfer_ok && status_ready && !ovf && (chg_x || chg_y || chg_z);

  // ---- health
  msqh_pkg::health_t health;

  msqh_health u_health (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .publish  (publish),
    .readback (check_readback),
    .now_us   (now_us),
    .cfg      (cfg_r),
    .health   (health)
  );

  always_comb begin
    res.publish_valid    = publish;
    res.mag_x            = publish ? or_x : '0;
    res.mag_y            = publish ? or_y : '0;
    res.mag_z            = publish ? or_z : '0;
    res.overflow_seen    = transfer_ok && ovf && !publish;
    res.bad_transfer     = !transfer_ok;
    res.check_done       = health.check_done;
    res.bad_register     = health.bad_register;
    res.reset_request    = health.reset_request;
    res.next_check_index = health.next_check_index;
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // a failed register check always asks for a reset and counts as a check
  a_bad_reg_resets: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_data_r.bad_register |->
      out_data_r.reset_request && out_data_r.check_done)
    else $error("bad register without reset request");

  // a published sample never carries a transfer or overflow fault
  a_publish_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_data_r.publish_valid |->
      !out_data_r.bad_transfer && !out_data_r.overflow_seen)
    else $error("published item flags a fault");

  // axes read zero unless published
  a_quiet_axes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_data_r.publish_valid |->
      out_data_r.mag_x == '0 && out_data_r.mag_y == '0 && out_data_r.mag_z == '0)
    else $error("axes driven without publish");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the magnetometer sample qualifier and health monitor.
module testbench;

  typedef msqh_pkg::cfg_t    cfg_t;
  typedef msqh_pkg::result_t result_t;

  localparam int StallLimit = 2000;
  // cfg index outside the register list, writes to it must be dropped
  localparam logic [2:0] RegUnused = 3'd7;

  // poll item, first field highest
  typedef struct packed {
    logic [31:0]        now_us;
    logic [7:0]         readback;
    logic [7:0]         status;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic               ok;
  } poll_t;

  // directed row: result typed in when fixed is set, else left to the predictor
  typedef struct {
    poll_t   item;
    bit      fixed;
    result_t want;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;

  mag_sample_qualifier_health_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor copy of the block's registers and state
  cfg_t               shadow;
  logic signed [15:0] prev_x, prev_y, prev_z;
  logic [7:0]         fail_cnt;
  logic [1:0]         chk_idx;
  logic [31:0]        last_chk;
  logic [31:0]        clock_us;

  result_t pending[$];
  row_t    fixed_outcomes[$];
  row_t    directed[$];

  int fault_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  int n_items = 0, n_published = 0, n_checks = 0, n_bad_checks = 0, n_resets = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] negate_clamped(input logic signed [15:0] v);
    return (v == msqh_pkg::SampleMin) ? msqh_pkg::SampleMax : -v;
  endfunction

  // One poll through the qualifier and the health monitor; updates the state copy.
  function automatic result_t qualify_poll(input poll_t p);
    result_t     r;
    logic        ready, ovf, changed, skip;
    logic [7:0]  sm, cm;
    logic [31:0] elapsed;
    int unsigned eff;
    r = '0;
    if (p.ok) begin
      ready   = |(p.status & shadow.ready_mask);
      ovf     = |(p.status & shadow.overflow_mask);
      changed = {p.x, p.y, p.z} != {prev_x, prev_y, prev_z};
      prev_x  = p.x;
      prev_y  = p.y;
      prev_z  = p.z;
      if (ready && !ovf && changed) begin
        r.publish_valid = 1'b1;
        r.mag_x = p.x;
        r.mag_y = negate_clamped(p.y);
        r.mag_z = negate_clamped(p.z);
        if (fail_cnt != 8'd0) fail_cnt--;
      end else if (ovf) begin
        r.overflow_seen = 1'b1;
      end
    end else begin
      r.bad_transfer = 1'b1;
    end
    skip = 1'b0;
    if (!r.publish_valid) begin
      if (fail_cnt != msqh_pkg::CounterTop) fail_cnt++;
      if (fail_cnt > shadow.failure_limit) begin
        r.reset_request = 1'b1;
        fail_cnt = 8'd0;
        skip = 1'b1;
      end
    end
    elapsed = p.now_us - last_chk;
    if (!skip && (!r.publish_valid || elapsed > shadow.check_interval_us)) begin
      sm = shadow.set_masks[8*chk_idx +: 8];
      cm = shadow.clear_masks[8*chk_idx +: 8];
      r.check_done = 1'b1;
      if ((p.readback & sm) == sm && (p.readback & cm) == 8'd0) begin
        // passed: index moves on modulo the clamped count, even from a stale index
        eff = (shadow.checked_count == 3'd0) ? 1 :
              (shadow.checked_count > 3'(msqh_pkg::MaxCheckedRegs)) ?
              msqh_pkg::MaxCheckedRegs : int'(shadow.checked_count);
        last_chk = p.now_us;
        chk_idx  = 2'((int'(chk_idx) + 1) % eff);
      end else begin
        r.bad_register  = 1'b1;
        r.reset_request = 1'b1;
        fail_cnt = 8'd0;
      end
    end
    r.next_check_index = chk_idx;
    return r;
  endfunction

  function automatic poll_t poll(input logic ok, input logic [15:0] x, y, z,
                                 input logic [7:0] st, rb, input logic [31:0] now);
    poll_t p;
    p.ok = ok;
    p.x = x;
    p.y = y;
    p.z = z;
    p.status = st;
    p.readback = rb;
    p.now_us = now;
    return p;
  endfunction

  function automatic result_t outcome(input logic pub, input logic [15:0] mx, my, mz,
                                      input logic ovf, bad, done, breg, rr,
                                      input logic [1:0] nidx);
    result_t r;
    r.publish_valid = pub;
    r.mag_x = mx;
    r.mag_y = my;
    r.mag_z = mz;
    r.overflow_seen = ovf;
    r.bad_transfer = bad;
    r.check_done = done;
    r.bad_register = breg;
    r.reset_request = rr;
    r.next_check_index = nidx;
    return r;
  endfunction

  function automatic logic [15:0] extreme_sample();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  // Mostly well-formed polls: ready status, fresh samples, a readback that fits
  // the masks of the register now under check, time near the check boundary.
  function automatic poll_t make_poll(input int rb_noise);
    poll_t      p;
    int         pick;
    logic [7:0] sm, cm;
    p.ok = ($urandom_range(99) >= 7);
    pick = $urandom_range(99);
    if (pick < 10) begin
      p.x = prev_x;
      p.y = prev_y;
      p.z = prev_z;
    end else if (pick < 20) begin
      p.x = extreme_sample();
      p.y = extreme_sample();
      p.z = extreme_sample();
    end else begin
      p.x = 16'($urandom);
      p.y = 16'($urandom);
      p.z = 16'($urandom);
    end
    if ($urandom_range(99) < 75)
      p.status = (8'($urandom) & ~shadow.overflow_mask) | shadow.ready_mask;
    else
      p.status = 8'($urandom);
    sm = shadow.set_masks[8*chk_idx +: 8];
    cm = shadow.clear_masks[8*chk_idx +: 8];
    if ($urandom_range(99) < rb_noise) p.readback = 8'($urandom);
    else p.readback = (8'($urandom) & ~cm) | sm;
    pick = $urandom_range(99);
    if (pick < 55) p.now_us = clock_us + 32'($urandom_range(0, 300));
    else if (pick < 85)
      p.now_us = last_chk + shadow.check_interval_us + 32'($urandom_range(0, 2)) - 32'd1;
    else if (pick < 95) p.now_us = clock_us + 32'($urandom_range(0, 200000));
    else p.now_us = $urandom;
    clock_us = p.now_us;
    return p;
  endfunction

  function automatic cfg_t random_settings(input logic [2:0] count);
    cfg_t c;
    c.ready_mask = 8'($urandom);
    c.overflow_mask = 8'($urandom) & ~c.ready_mask;
    c.failure_limit = 8'($urandom_range(0, 30));
    c.check_interval_us = $urandom_range(0, 2000);
    c.checked_count = count;
    c.set_masks = $urandom;
    c.clear_masks = $urandom & ~c.set_masks;
    return c;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // cfg writes, predictions and result checks, all on the rising edge
  always @(posedge clk) begin
    result_t predicted;
    result_t got;
    row_t    row;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          msqh_pkg::RegReadyMask:     shadow.ready_mask = cfg_data[7:0];
          msqh_pkg::RegOverflowMask:  shadow.overflow_mask = cfg_data[7:0];
          msqh_pkg::RegFailureLimit:  shadow.failure_limit = cfg_data[7:0];
          msqh_pkg::RegCheckInterval: shadow.check_interval_us = cfg_data;
          msqh_pkg::RegCheckedCount:  shadow.checked_count = cfg_data[2:0];
          msqh_pkg::RegSetMasks:      shadow.set_masks = cfg_data;
          msqh_pkg::RegClearMasks:    shadow.clear_masks = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predicted = qualify_poll(poll_t'(in_tdata[96:0]));
        if (fixed_outcomes.size() != 0) begin
          row = fixed_outcomes.pop_front();
          if (row.fixed) predicted = row.want;
        end
        pending.push_back(predicted);
        n_items++;
        n_published += predicted.publish_valid;
        n_checks += predicted.check_done;
        n_bad_checks += predicted.bad_register;
        n_resets += predicted.reset_request;
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (pending.size() == 0) begin
          fault_count++;
          $display("%0t: result with nothing expected, got %h", $time, out_tdata);
        end else begin
          predicted = pending.pop_front();
          compare_field("publish_valid", 16'(predicted.publish_valid), 16'(got.publish_valid));
          compare_field("mag_x", predicted.mag_x, got.mag_x);
          compare_field("mag_y", predicted.mag_y, got.mag_y);
          compare_field("mag_z", predicted.mag_z, got.mag_z);
          compare_field("overflow_seen", 16'(predicted.overflow_seen), 16'(got.overflow_seen));
          compare_field("bad_transfer", 16'(predicted.bad_transfer), 16'(got.bad_transfer));
          compare_field("check_done", 16'(predicted.check_done), 16'(got.check_done));
          compare_field("bad_register", 16'(predicted.bad_register), 16'(got.bad_register));
          compare_field("reset_request", 16'(predicted.reset_request),
                        16'(got.reset_request));
          compare_field("next_check_index", 16'(predicted.next_check_index),
                        16'(got.next_check_index));
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // called on a falling edge; returns on the falling edge after acceptance
  task automatic send_poll(input poll_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, p};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // hold the sender until every result is back, then wait extra cycles
  task automatic drain(input int extra);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  // writes every index, the unused one included
  task automatic apply_settings(input cfg_t c);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      case (3'(i))
        msqh_pkg::RegReadyMask:     cfg_data <= 32'(c.ready_mask);
        msqh_pkg::RegOverflowMask:  cfg_data <= 32'(c.overflow_mask);
        msqh_pkg::RegFailureLimit:  cfg_data <= 32'(c.failure_limit);
        msqh_pkg::RegCheckInterval: cfg_data <= c.check_interval_us;
        msqh_pkg::RegCheckedCount:  cfg_data <= 32'(c.checked_count);
        msqh_pkg::RegSetMasks:      cfg_data <= c.set_masks;
        msqh_pkg::RegClearMasks:    cfg_data <= c.clear_masks;
        default:                    cfg_data <= $urandom;
      endcase
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input cfg_t c, input int send_pct, input int recv_pct,
                           input int count, input int rb_noise, input int pause_every);
    drain(3);
    apply_settings(c);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (pause_every != 0 && n % pause_every == pause_every - 1) drain(0);
      send_poll(make_poll(rb_noise));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    shadow = '{ready_mask: msqh_pkg::ReadyMaskRst,
               overflow_mask: msqh_pkg::OverflowMaskRst,
               failure_limit: msqh_pkg::FailureLimitRst,
               check_interval_us: msqh_pkg::CheckIntervalRst,
               checked_count: msqh_pkg::CheckedCountRst, set_masks: '0, clear_masks: '0};
    prev_x = '0;
    prev_y = '0;
    prev_z = '0;
    fail_cnt = '0;
    chk_idx = '0;
    last_chk = '0;
    clock_us = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: low failure limit, entry 0 needs bits 0x81 set, entry 1 bits 0x42 clear
    apply_settings('{ready_mask: 8'h01, overflow_mask: 8'h02, failure_limit: 8'd3,
                     check_interval_us: 32'd100000, checked_count: 3'd3,
                     set_masks: 32'h0000_0081, clear_masks: 32'h0000_4200});
    send_idle_pct = 38;
    recv_idle_pct = 64;
    directed = '{
      // unchanged zero triple after reset: failure, check of entry 0 passes
      '{poll(1, 16'h0000, 16'h0000, 16'h0000, 8'h01, 8'h81, 32'd5), 1'b1,
        outcome(0, 16'h0, 16'h0, 16'h0, 0, 0, 1, 0, 0, 2'd1)},
      // Y and Z at the negative end clamp to the positive top
      '{poll(1, 16'h7fff, 16'h8000, 16'h8000, 8'h01, 8'h00, 32'd10), 1'b1,
        outcome(1, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0, 2'd1)},
      '{poll(1, 16'h8000, 16'h7fff, 16'h0001, 8'h01, 8'h00, 32'd20), 1'b1,
        outcome(1, 16'h8000, 16'h8001, 16'hffff, 0, 0, 0, 0, 0, 2'd1)},
      // overflow bit with ready bit
      '{poll(1, 16'h0001, 16'h0002, 16'h0003, 8'h03, 8'h00, 32'd30), 1'b1,
        outcome(0, 16'h0, 16'h0, 16'h0, 1, 0, 1, 0, 0, 2'd2)},
      // failed transfer, empty masks of entry 2 pass whatever the readback
      '{poll(0, 16'h1234, 16'h5678, 16'h1abc, 8'hff, 8'hff, 32'd40), 1'b1,
        outcome(0, 16'h0, 16'h0, 16'h0, 0, 1, 1, 0, 0, 2'd0)},
      // samples of the failed transfer were dropped, so this repeats: set bit missing
      '{poll(1, 16'h0001, 16'h0002, 16'h0003, 8'h01, 8'h01, 32'd45), 1'b1,
        outcome(0, 16'h0, 16'h0, 16'h0, 0, 0, 1, 1, 1, 2'd0)},
      '{poll(1, 16'hffff, 16'hffff, 16'hffff, 8'h80, 8'hc3, 32'd50), 1'b0, result_t'(0)},
      // clear bits set in entry 1
      '{poll(1, 16'hffff, 16'hffff, 16'hffff, 8'h01, 8'h42, 32'd55), 1'b1,
        outcome(0, 16'h0, 16'h0, 16'h0, 0, 0, 1, 1, 1, 2'd1)},
      '{poll(0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 32'd60), 1'b0, result_t'(0)},
      '{poll(0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h5a, 32'd70), 1'b0, result_t'(0)},
      '{poll(0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'hff, 32'd80), 1'b0, result_t'(0)},
      // fourth failure in a row passes the limit: reset request, no check
      '{poll(0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 32'd90), 1'b1,
        outcome(0, 16'h0, 16'h0, 16'h0, 0, 1, 0, 0, 1, 2'd1)},
      // elapsed exactly the interval, then one above
      '{poll(1, 16'h0005, 16'h0006, 16'h0007, 8'h01, 8'h00, 32'd100080), 1'b0, result_t'(0)},
      '{poll(1, 16'h0006, 16'h0006, 16'h0007, 8'h01, 8'h00, 32'd100081), 1'b0, result_t'(0)},
      // time wraps through zero
      '{poll(1, 16'h0007, 16'h0006, 16'h0007, 8'h01, 8'h00, 32'hffff_fff0), 1'b0,
        result_t'(0)},
      '{poll(1, 16'h0008, 16'h0006, 16'h0007, 8'h01, 8'h81, 32'h0000_0010), 1'b0,
        result_t'(0)},
      '{poll(1, 16'h0009, 16'h0006, 16'h0007, 8'h01, 8'h81, 32'h0001_86b1), 1'b0,
        result_t'(0)},
      '{poll(1, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 32'hffff_ffff), 1'b0,
        result_t'(0)},
      '{poll(0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 32'h0000_0000), 1'b0,
        result_t'(0)}
    };
    foreach (directed[i]) begin
      fixed_outcomes.push_back(directed[i]);
      send_poll(directed[i].item);
    end
    clock_us = 32'd0;

    // typical masks, sender pauses for a full drain now and then
    run_phase('{ready_mask: 8'h01, overflow_mask: 8'h02, failure_limit: 8'd10,
                check_interval_us: 32'd5000, checked_count: 3'd3,
                set_masks: 32'h0012_0081, clear_masks: 32'h4000_2402},
              38, 64, 400, 6, 150);
    // zero limit and interval, count 0 treated as 1, every set bit required
    run_phase('{ready_mask: 8'hff, overflow_mask: 8'h00, failure_limit: 8'd0,
                check_interval_us: 32'd0, checked_count: 3'd0,
                set_masks: 32'hffff_ffff, clear_masks: 32'h0000_0000},
              64, 38, 300, 6, 0);
    // never ready: failure counter climbs to its top and stays, count 7 clamps to 4
    run_phase('{ready_mask: 8'h00, overflow_mask: 8'hff, failure_limit: 8'd255,
                check_interval_us: 32'hffff_ffff, checked_count: 3'd7,
                set_masks: 32'h0000_0000, clear_masks: 32'hffff_ffff},
              0, 0, 400, 0, 0);
    // count drops to 2 so an index left at 2 or 3 goes stale
    run_phase(random_settings(3'd2), 0, 0, 300, 6, 0);
    run_phase(random_settings(3'($urandom_range(0, 7))), 0, 0, 350, 6, 0);
    drain(4);

    $display("Ran %0d polls, directed table then five random phases: %0d published,",
             n_items, n_published);
    $display("%0d checks (%0d failed), %0d reset requests; %0d mismatches",
             n_checks, n_bad_checks, n_resets, fault_count);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== mag_sample_qualifier_health_core.f =====
design/msqh_pkg.sv
design/msqh_axis_lane.sv
design/msqh_health.sv
design/mag_sample_qualifier_health_core.sv
verif/testbench.sv
